// File: hw/rtl/rct_pkg.sv
// Shared types and constants for the reference count table.
// No dependencies; used by rct_in_if, rct_out_if and reference_count_table_core.
package rct_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int AW          = $clog2(MAX_ENTRIES);     // entry index width
    localparam int CW          = $clog2(MAX_ENTRIES + 1); // entry count width
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 16;
    localparam int SIZE_W      = 32;
    localparam int KIND_W      = 3;
    localparam int BYTES_W     = 48;

    // Operation codes
    localparam logic [2:0] FN_TRACK   = 3'd0;
    localparam logic [2:0] FN_RETAIN  = 3'd1;
    localparam logic [2:0] FN_RELEASE = 3'd2;
    localparam logic [2:0] FN_COLLECT = 3'd3;
    localparam logic [2:0] FN_SETCNT  = 3'd4;
    localparam logic [2:0] FN_QUERY   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_FREED   = 2'd3;

    // Register byte addresses
    localparam int          PADDR_W     = 3;
    localparam logic [2:0]  ADDR_THRESH = 3'd0;
    localparam logic [2:0]  ADDR_AUTO   = 3'd4;
    localparam logic [15:0] THRESH_RST  = 16'd100;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  refs;
        logic [SIZE_W-1:0] bytes;
        logic [KIND_W-1:0] kind;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_RESP
    } t_state;

endpackage

// File: hw/rtl/rct_in_if.sv
// Request channel: valid/ready handshake carrying one operation word.
// Depends on rct_pkg for field widths.
interface rct_in_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  func;
    logic [rct_pkg::KEY_W-1:0]   key;
    logic [rct_pkg::SIZE_W-1:0]  obj_size;
    logic [rct_pkg::KIND_W-1:0]  obj_kind;
    logic [rct_pkg::CNT_W-1:0]   new_count;

    modport source (output valid, func, key, obj_size, obj_kind, new_count, input ready);
    modport sink   (input valid, func, key, obj_size, obj_kind, new_count, output ready);
endinterface

// File: hw/rtl/rct_out_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on rct_pkg for field widths.
interface rct_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [rct_pkg::CNT_W-1:0]    ref_count_now;
    logic [10:0]                  swept_count;
    logic [rct_pkg::BYTES_W-1:0]  live_bytes;
    logic [10:0]                  entries_tracked;
    logic [31:0]                  sweeps_done;

    modport source (output valid, status, ref_count_now, swept_count, live_bytes,
                    entries_tracked, sweeps_done, input ready);
    modport sink   (input valid, status, ref_count_now, swept_count, live_bytes,
                    entries_tracked, sweeps_done, output ready);
endinterface

// File: hw/rtl/reference_count_table_core.sv
// Reference count table core: entry memory, lookup scan, compaction walk.
// Depends on rct_pkg, rct_in_if, rct_out_if.
//
//  channel   dir  handshake          word
//  i_req     in   valid/ready        func, key, obj_size, obj_kind, new_count
//  o_rsp     out  valid/ready        status, ref_count_now, swept_count, stats
//  apb       in   psel/penable       sweep_threshold @0x0, auto_sweep_on @0x4
//
// Track words without an auto sweep, and invalid or rejected words, go from
// S_IDLE straight to S_RESP. Lookups scan from index 0 on the single read
// port, one entry a cycle, up to a hit or the end of the table. Release-to-zero,
// collect and auto sweep add a walk from start to used, one entry read a cycle
// and each kept entry written back; a release that frees an entry takes longest.
// Reset is synchronous; the entry memory is not cleared. A stalled response
// holds the core in S_RESP.
module reference_count_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rct_in_if.sink                       i_req,
    rct_out_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rct_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Entry memory
    rct_pkg::t_entry mem [rct_pkg::MAX_ENTRIES];
    rct_pkg::t_entry r_rd_data;
    rct_pkg::t_entry mem_wdata;
    logic [rct_pkg::AW-1:0] mem_waddr;
    logic                   mem_we;

    rct_pkg::t_state r_state, n_state;

    logic [2:0]                  r_func, n_func;
    logic [rct_pkg::KEY_W-1:0]   r_key, n_key;
    logic [rct_pkg::CNT_W-1:0]   r_ncount, n_ncount;
    logic [rct_pkg::CW-1:0]      r_used, n_used;
    logic [15:0]                 r_tracks, n_tracks;
    logic [rct_pkg::BYTES_W-1:0] r_alloc, n_alloc;
    logic [rct_pkg::BYTES_W-1:0] r_freed, n_freed;
    logic [31:0]                 r_sweeps, n_sweeps;
    logic [15:0]                 r_thresh;
    logic                        r_auto;
    logic [rct_pkg::CW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [rct_pkg::CW-1:0]      r_wr_ptr, n_wr_ptr;
    logic                        r_chk_vld, n_chk_vld;
    logic [rct_pkg::AW-1:0]      r_chk_idx, n_chk_idx;
    logic [rct_pkg::AW-1:0]      r_start, n_start;
    logic                        r_sweep_mode, n_sweep_mode;
    logic [rct_pkg::CW-1:0]      r_drop_n, n_drop_n;
    logic [1:0]                  r_res_status, n_res_status;
    logic [rct_pkg::CNT_W-1:0]   r_res_refs, n_res_refs;
    logic [rct_pkg::CW-1:0]      r_res_swept, n_res_swept;

    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_o_status, n_o_status;
    logic [rct_pkg::CNT_W-1:0]   r_o_refs, n_o_refs;
    logic [10:0]                 r_o_swept, n_o_swept;
    logic [rct_pkg::BYTES_W-1:0] r_o_live, n_o_live;
    logic [10:0]                 r_o_used, n_o_used;
    logic [31:0]                 r_o_sweeps, n_o_sweeps;

    // Shared decisions
    logic        accept, trk_bad, trk_full, trk_sweep, hit, scan_miss, walk_done;
    logic        drop, out_free;
    logic [15:0] tracks_inc;

    assign accept     = i_req.valid && (r_state == rct_pkg::S_IDLE);
    assign trk_bad    = (i_req.key == '0) || (i_req.obj_size == '0);
    assign trk_full   = (r_used >= rct_pkg::CW'(rct_pkg::MAX_ENTRIES));
    assign tracks_inc = (r_tracks == 16'hFFFF) ? r_tracks : r_tracks + 16'd1;
    assign trk_sweep  = r_auto && (tracks_inc >= r_thresh);
    assign hit        = r_chk_vld && (r_rd_data.key == r_key);
    assign scan_miss  = !hit && (r_rd_ptr >= r_used);
    assign walk_done  = !r_chk_vld && (r_rd_ptr >= r_used);
    assign drop       = r_sweep_mode ? (r_rd_data.refs == '0) : (r_chk_idx == r_start);
    assign out_free   = !r_out_valid || o_rsp.ready;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_rd_ptr[rct_pkg::AW-1:0]];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rct_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.func)
                        rct_pkg::FN_TRACK: begin
                            n_state = (!trk_bad && !trk_full && trk_sweep) ?
                                      rct_pkg::S_WALK : rct_pkg::S_RESP;
                        end
                        rct_pkg::FN_COLLECT: n_state = rct_pkg::S_WALK;
                        rct_pkg::FN_RETAIN, rct_pkg::FN_RELEASE,
                        rct_pkg::FN_SETCNT, rct_pkg::FN_QUERY: begin
                            n_state = (i_req.key == '0) ? rct_pkg::S_RESP : rct_pkg::S_SCAN;
                        end
                        default: n_state = rct_pkg::S_RESP;
                    endcase
                end
            end
            rct_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = (r_func == rct_pkg::FN_RELEASE && r_rd_data.refs <= 1) ?
                              rct_pkg::S_WALK : rct_pkg::S_RESP;
                end else if (scan_miss) begin
                    n_state = rct_pkg::S_RESP;
                end
            end
            rct_pkg::S_WALK: begin
                if (walk_done) n_state = rct_pkg::S_RESP;
            end
            rct_pkg::S_RESP: begin
                if (out_free) n_state = rct_pkg::S_IDLE;
            end
            default: n_state = rct_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_func = r_func;  n_key = r_key;  n_ncount = r_ncount;
        n_used = r_used;  n_tracks = r_tracks;  n_alloc = r_alloc;
        n_freed = r_freed;  n_sweeps = r_sweeps;
        n_rd_ptr = r_rd_ptr;  n_wr_ptr = r_wr_ptr;  n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;  n_start = r_start;  n_sweep_mode = r_sweep_mode;
        n_drop_n = r_drop_n;  n_res_status = r_res_status;
        n_res_refs = r_res_refs;  n_res_swept = r_res_swept;
        n_out_valid = r_out_valid;  n_o_status = r_o_status;  n_o_refs = r_o_refs;
        n_o_swept = r_o_swept;  n_o_live = r_o_live;  n_o_used = r_o_used;
        n_o_sweeps = r_o_sweeps;
        mem_we = 1'b0;
        mem_waddr = r_chk_idx;
        mem_wdata = r_rd_data;

        if (o_rsp.valid && o_rsp.ready) n_out_valid = 1'b0;

        case (r_state)
            rct_pkg::S_IDLE: begin
                if (accept) begin
                    n_func = i_req.func;  n_key = i_req.key;  n_ncount = i_req.new_count;
                    n_res_status = rct_pkg::ST_OK;
                    n_res_refs = '0;
                    n_res_swept = '0;
                    n_rd_ptr = '0;  n_wr_ptr = '0;  n_chk_vld = 1'b0;
                    n_sweep_mode = 1'b1;  n_drop_n = '0;
                    case (i_req.func)
                        rct_pkg::FN_TRACK: begin
                            if (trk_bad) begin
                                n_res_status = rct_pkg::ST_INVALID;
                            end else if (trk_full) begin
                                n_res_status = rct_pkg::ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_waddr = r_used[rct_pkg::AW-1:0];
                                mem_wdata.key = i_req.key;
                                mem_wdata.refs = rct_pkg::CNT_W'(1);
                                mem_wdata.bytes = i_req.obj_size;
                                mem_wdata.kind = i_req.obj_kind;
                                n_used = r_used + rct_pkg::CW'(1);
                                n_alloc = r_alloc + rct_pkg::BYTES_W'(i_req.obj_size);
                                n_res_refs = rct_pkg::CNT_W'(1);
                                n_tracks = trk_sweep ? 16'd0 : tracks_inc;
                            end
                        end
                        rct_pkg::FN_COLLECT: ;
                        rct_pkg::FN_RETAIN, rct_pkg::FN_RELEASE,
                        rct_pkg::FN_SETCNT, rct_pkg::FN_QUERY: begin
                            if (i_req.key == '0) n_res_status = rct_pkg::ST_INVALID;
                        end
                        default: n_res_status = rct_pkg::ST_INVALID;
                    endcase
                end
            end
            rct_pkg::S_SCAN: begin
                if (hit) begin
                    mem_waddr = r_chk_idx;
                    case (r_func)
                        rct_pkg::FN_RETAIN: begin
                            mem_we = 1'b1;
                            mem_wdata.refs = (r_rd_data.refs == rct_pkg::CNT_MAX) ?
                                             r_rd_data.refs : r_rd_data.refs + 1'b1;
                            n_res_refs = mem_wdata.refs;
                        end
                        rct_pkg::FN_SETCNT: begin
                            mem_we = 1'b1;
                            mem_wdata.refs = r_ncount;
                            n_res_refs = r_ncount;
                        end
                        rct_pkg::FN_RELEASE: begin
                            if (r_rd_data.refs <= 1) begin
                                // remove and compact from the hit onward
                                n_res_status = rct_pkg::ST_FREED;
                                n_rd_ptr = rct_pkg::CW'(r_chk_idx);
                                n_wr_ptr = rct_pkg::CW'(r_chk_idx);
                                n_start = r_chk_idx;
                                n_sweep_mode = 1'b0;
                                n_chk_vld = 1'b0;
                            end else begin
                                mem_we = 1'b1;
                                mem_wdata.refs = r_rd_data.refs - 1'b1;
                                n_res_refs = mem_wdata.refs;
                            end
                        end
                        default: n_res_refs = r_rd_data.refs;
                    endcase
                end else if (scan_miss) begin
                    n_res_status = rct_pkg::ST_INVALID;
                end else begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_ptr[rct_pkg::AW-1:0];
                    n_rd_ptr = r_rd_ptr + rct_pkg::CW'(1);
                end
            end
            rct_pkg::S_WALK: begin
                // retire the entry read last cycle
                if (r_chk_vld) begin
                    if (drop) begin
                        n_freed = r_freed + rct_pkg::BYTES_W'(r_rd_data.bytes);
                        n_drop_n = r_drop_n + rct_pkg::CW'(1);
                    end else begin
                        mem_we = 1'b1;
                        mem_waddr = r_wr_ptr[rct_pkg::AW-1:0];
                        n_wr_ptr = r_wr_ptr + rct_pkg::CW'(1);
                    end
                end
                if (r_rd_ptr < r_used) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_ptr[rct_pkg::AW-1:0];
                    n_rd_ptr = r_rd_ptr + rct_pkg::CW'(1);
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (walk_done) begin
                    n_used = r_wr_ptr;
                    if (r_sweep_mode) begin
                        n_sweeps = r_sweeps + 32'd1;
                        n_res_swept = r_drop_n;
                    end
                end
            end
            rct_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status = r_res_status;
                    n_o_refs = r_res_refs;
                    n_o_swept = 11'(r_res_swept);
                    n_o_live = r_alloc - r_freed;
                    n_o_used = 11'(r_used);
                    n_o_sweeps = r_sweeps;
                end
            end
            default: ;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rct_pkg::S_IDLE;
            r_used <= '0;
            r_tracks <= '0;
            r_alloc <= '0;
            r_freed <= '0;
            r_sweeps <= '0;
            r_chk_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_tracks <= n_tracks;
            r_alloc <= n_alloc;
            r_freed <= n_freed;
            r_sweeps <= n_sweeps;
            r_chk_vld <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
        r_func <= n_func;  r_key <= n_key;  r_ncount <= n_ncount;
        r_rd_ptr <= n_rd_ptr;  r_wr_ptr <= n_wr_ptr;  r_chk_idx <= n_chk_idx;
        r_start <= n_start;  r_sweep_mode <= n_sweep_mode;  r_drop_n <= n_drop_n;
        r_res_status <= n_res_status;  r_res_refs <= n_res_refs;
        r_res_swept <= n_res_swept;
        r_o_status <= n_o_status;  r_o_refs <= n_o_refs;  r_o_swept <= n_o_swept;
        r_o_live <= n_o_live;  r_o_used <= n_o_used;  r_o_sweeps <= n_o_sweeps;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= rct_pkg::THRESH_RST;
            r_auto <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr == rct_pkg::ADDR_THRESH && pwdata[15:0] != 16'd0) begin
                r_thresh <= pwdata[15:0];
            end else if (paddr == rct_pkg::ADDR_AUTO) begin
                r_auto <= pwdata[0];
            end
        end
    end

    always_comb begin
        case (paddr)
            rct_pkg::ADDR_THRESH: prdata = {16'd0, r_thresh};
            rct_pkg::ADDR_AUTO:   prdata = {31'd0, r_auto};
            default:              prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // Channel ports
    assign i_req.ready           = (r_state == rct_pkg::S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.ref_count_now   = r_o_refs;
    assign o_rsp.swept_count     = r_o_swept;
    assign o_rsp.live_bytes      = r_o_live;
    assign o_rsp.entries_tracked = r_o_used;
    assign o_rsp.sweeps_done     = r_o_sweeps;

    // Checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= rct_pkg::CW'(rct_pkg::MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rct_pkg::S_WALK) |-> (r_wr_ptr <= r_rd_ptr))
        else $error("compaction write pointer passed read pointer");

    a_freed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == rct_pkg::ST_FREED) |-> (o_rsp.ref_count_now == '0))
        else $error("freed entry reported with nonzero count");

endmodule

// File: verif/rct_table_checker.sv
// Checker for the reference count table: predicts each result word and compares it.
// Depends on rct_pkg, rct_in_if and rct_out_if; watches the request, response and APB writes.
module rct_table_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rct_in_if                            req,
    rct_out_if                           rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [rct_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output int                           o_fails,
    output int                           o_pending,
    output int                           o_results
);

    typedef struct packed {
        logic [1:0]                  status;
        logic [rct_pkg::CNT_W-1:0]   refs;
        logic [10:0]                 swept;
        logic [rct_pkg::BYTES_W-1:0] live;
        logic [10:0]                 used;
        logic [31:0]                 sweeps;
    } t_result;

    // Shadow copy of the table and its statistics
    logic [rct_pkg::KEY_W-1:0]   tab_key   [rct_pkg::MAX_ENTRIES];
    logic [rct_pkg::CNT_W-1:0]   tab_refs  [rct_pkg::MAX_ENTRIES];
    logic [rct_pkg::SIZE_W-1:0]  tab_bytes [rct_pkg::MAX_ENTRIES];
    logic [rct_pkg::KIND_W-1:0]  tab_kind  [rct_pkg::MAX_ENTRIES];
    int unsigned                 used;
    logic [15:0]                 tracks_pending;
    logic [rct_pkg::BYTES_W-1:0] alloc_bytes;
    logic [rct_pkg::BYTES_W-1:0] freed_bytes;
    logic [31:0]                 sweep_total;
    logic [15:0]                 thresh;
    logic                        auto_on;

    t_result rsp_expected[$];

    assign o_pending = rsp_expected.size();

    // Drop zero-count entries, keeping order; returns how many went
    function automatic logic [10:0] sweep_zero();
        int unsigned w;
        int unsigned n;
        w = 0;
        n = 0;
        for (int unsigned r = 0; r < used; r++) begin
            if (tab_refs[r] == '0) begin
                freed_bytes = freed_bytes + rct_pkg::BYTES_W'(tab_bytes[r]);
                n++;
            end else begin
                tab_key[w]   = tab_key[r];
                tab_refs[w]  = tab_refs[r];
                tab_bytes[w] = tab_bytes[r];
                tab_kind[w]  = tab_kind[r];
                w++;
            end
        end
        used = w;
        sweep_total = sweep_total + 32'd1;
        return 11'(n);
    endfunction

    function automatic int unsigned find_oldest(logic [rct_pkg::KEY_W-1:0] k);
        for (int unsigned i = 0; i < used; i++)
            if (tab_key[i] == k) return i;
        return used;
    endfunction

    // Apply one operation word to the shadow table, return its result word
    function automatic t_result table_apply(logic [2:0] fn, logic [rct_pkg::KEY_W-1:0] k,
                                            logic [rct_pkg::SIZE_W-1:0] sz,
                                            logic [rct_pkg::KIND_W-1:0] kd,
                                            logic [rct_pkg::CNT_W-1:0] nc);
        t_result     r;
        int unsigned idx;
        r = '0;
        if (fn == rct_pkg::FN_TRACK) begin
            if (k == '0 || sz == '0) begin
                r.status = rct_pkg::ST_INVALID;
            end else if (used >= rct_pkg::MAX_ENTRIES) begin
                r.status = rct_pkg::ST_FULL;
            end else begin
                tab_key[used]   = k;
                tab_refs[used]  = rct_pkg::CNT_W'(1);
                tab_bytes[used] = sz;
                tab_kind[used]  = kd;
                used++;
                alloc_bytes = alloc_bytes + rct_pkg::BYTES_W'(sz);
                r.refs = rct_pkg::CNT_W'(1);
                if (tracks_pending != 16'hFFFF) tracks_pending++;
                if (auto_on && tracks_pending >= thresh) begin
                    r.swept = sweep_zero();
                    tracks_pending = '0;
                end
            end
        end else if (fn == rct_pkg::FN_COLLECT) begin
            r.swept = sweep_zero();
        end else if (fn == rct_pkg::FN_RETAIN || fn == rct_pkg::FN_RELEASE ||
                     fn == rct_pkg::FN_SETCNT || fn == rct_pkg::FN_QUERY) begin
            idx = (k == '0) ? used : find_oldest(k);
            if (idx >= used) begin
                r.status = rct_pkg::ST_INVALID;
            end else if (fn == rct_pkg::FN_RETAIN) begin
                if (tab_refs[idx] != rct_pkg::CNT_MAX) tab_refs[idx]++;
                r.refs = tab_refs[idx];
            end else if (fn == rct_pkg::FN_RELEASE) begin
                if (tab_refs[idx] <= 1) begin
                    freed_bytes = freed_bytes + rct_pkg::BYTES_W'(tab_bytes[idx]);
                    for (int unsigned j = idx; j + 1 < used; j++) begin
                        tab_key[j]   = tab_key[j+1];
                        tab_refs[j]  = tab_refs[j+1];
                        tab_bytes[j] = tab_bytes[j+1];
                        tab_kind[j]  = tab_kind[j+1];
                    end
                    used--;
                    r.status = rct_pkg::ST_FREED;
                end else begin
                    tab_refs[idx]--;
                    r.refs = tab_refs[idx];
                end
            end else if (fn == rct_pkg::FN_SETCNT) begin
                tab_refs[idx] = nc;
                r.refs = nc;
            end else begin
                r.refs = tab_refs[idx];
            end
        end else begin
            r.status = rct_pkg::ST_INVALID;
        end
        r.live   = alloc_bytes - freed_bytes;
        r.used   = 11'(used);
        r.sweeps = sweep_total;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        o_fails++;
        if (o_fails <= 10)
            $display("mismatch on result %0d: %s expected %0h got %0h",
                     o_results, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            used           = 0;
            tracks_pending = '0;
            alloc_bytes    = '0;
            freed_bytes    = '0;
            sweep_total    = '0;
            thresh         = rct_pkg::THRESH_RST;
            auto_on        = 1'b1;
            o_fails        = 0;
            o_results      = 0;
            rsp_expected.delete();
        end else begin
            // Register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == rct_pkg::ADDR_THRESH && pwdata[15:0] != '0)
                    thresh = pwdata[15:0];
                else if (paddr == rct_pkg::ADDR_AUTO)
                    auto_on = pwdata[0];
            end
            // Compare an accepted result word with the oldest expectation
            if (rsp.valid && rsp.ready) begin
                o_results++;
                if (rsp_expected.size() == 0) begin
                    report("unexpected word", 64'd0, 64'(rsp.status));
                end else begin
                    e = rsp_expected.pop_front();
                    if (rsp.status !== e.status)
                        report("status", 64'(e.status), 64'(rsp.status));
                    if (rsp.ref_count_now !== e.refs)
                        report("ref_count_now", 64'(e.refs), 64'(rsp.ref_count_now));
                    if (rsp.swept_count !== e.swept)
                        report("swept_count", 64'(e.swept), 64'(rsp.swept_count));
                    if (rsp.live_bytes !== e.live)
                        report("live_bytes", 64'(e.live), 64'(rsp.live_bytes));
                    if (rsp.entries_tracked !== e.used)
                        report("entries_tracked", 64'(e.used), 64'(rsp.entries_tracked));
                    if (rsp.sweeps_done !== e.sweeps)
                        report("sweeps_done", 64'(e.sweeps), 64'(rsp.sweeps_done));
                end
            end
            // Predict the result of an accepted request word
            if (req.valid && req.ready)
                rsp_expected.push_back(table_apply(req.func, req.key, req.obj_size,
                                                   req.obj_kind, req.new_count));
        end
    end
endmodule

// File: verif/reference_count_table_core_test.sv
// Top of the reference count table testbench: clock, reset, stimulus and verdict.
// Depends on rct_pkg, rct_in_if, rct_out_if, reference_count_table_core and rct_table_checker.
module reference_count_table_core_test;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rct_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        quiet;
    logic                        gaps_on;
    int                          stall_left;
    int                          fails;
    int                          pending;
    int                          results;
    int                          words_sent;

    rct_in_if  req ();
    rct_out_if rsp ();

    reference_count_table_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rct_table_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_fails   (fails),
        .o_pending (pending),
        .o_results (results)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Response stalls in random bursts, none in quiet mode
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            rsp.ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    // Send one request word; may idle first
    task automatic send_word(logic [2:0] fn, logic [rct_pkg::KEY_W-1:0] k,
                             logic [rct_pkg::SIZE_W-1:0] sz,
                             logic [rct_pkg::KIND_W-1:0] kd,
                             logic [rct_pkg::CNT_W-1:0] nc);
        int gap;
        gap = (!quiet && gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.func      <= fn;
        req.key       <= k;
        req.obj_size  <= sz;
        req.obj_kind  <= kd;
        req.new_count <= nc;
        @(posedge i_clk);
        while (!(req.valid && req.ready)) @(posedge i_clk);
        words_sent++;
    endtask

    // Let everything drain before touching registers
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [rct_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [rct_pkg::KEY_W-1:0] pick_key();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) return rct_pkg::KEY_W'($urandom_range(1, 12));
        if (p < 85) return $urandom;
        if (p < 93) return '0;
        return '1;
    endfunction

    function automatic logic [rct_pkg::CNT_W-1:0] pick_count();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4) return '0;
        if (p < 6) return rct_pkg::CNT_W'($urandom_range(1, 3));
        if (p < 8) return rct_pkg::CNT_W'($urandom_range(0, 65535));
        return rct_pkg::CNT_MAX - rct_pkg::CNT_W'($urandom_range(0, 1));
    endfunction

    // Random words with a mix that keeps the table short
    task automatic random_words(int n);
        int          p;
        logic [2:0]  fn;
        logic [31:0] sz;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 27) fn = rct_pkg::FN_TRACK;
            else if (p < 37) fn = rct_pkg::FN_RETAIN;
            else if (p < 62) fn = rct_pkg::FN_RELEASE;
            else if (p < 70) fn = rct_pkg::FN_COLLECT;
            else if (p < 84) fn = rct_pkg::FN_SETCNT;
            else if (p < 96) fn = rct_pkg::FN_QUERY;
            else fn = 3'($urandom_range(6, 7));
            sz = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
            send_word(fn, pick_key(), sz, 3'($urandom_range(0, 7)), pick_count());
            if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        quiet         <= 1'b0;
        gaps_on       = 1'b1;
        words_sent    = 0;
        req.valid     <= 1'b0;
        req.func      <= rct_pkg::FN_TRACK;
        req.key       <= '0;
        req.obj_size  <= '0;
        req.obj_kind  <= '0;
        req.new_count <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: rejects, duplicates, saturation, freeing at zero, unused codes
        send_word(rct_pkg::FN_TRACK,   '0,    32'd10,        3'd1, '0);
        send_word(rct_pkg::FN_TRACK,   32'd5, '0,            3'd1, '0);
        send_word(rct_pkg::FN_TRACK,   '1,    '1,            3'd7, '0);
        send_word(rct_pkg::FN_TRACK,   32'd5, 32'd100,       3'd0, '0);
        send_word(rct_pkg::FN_TRACK,   32'd5, 32'd200,       3'd3, '0);
        send_word(rct_pkg::FN_QUERY,   32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_RETAIN,  '0,    '0,            '0,   '0);
        send_word(rct_pkg::FN_RETAIN,  32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_SETCNT,  32'd5, '0,            '0,   rct_pkg::CNT_MAX - 16'd1);
        send_word(rct_pkg::FN_RETAIN,  32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_RETAIN,  32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_SETCNT,  '1,    '0,            '0,   rct_pkg::CNT_MAX);
        send_word(rct_pkg::FN_SETCNT,  32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_COLLECT, '0,    '0,            '0,   '0);
        send_word(rct_pkg::FN_QUERY,   32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_RELEASE, 32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_RELEASE, 32'd5, '0,            '0,   '0);
        send_word(rct_pkg::FN_TRACK,   32'd7, 32'h8000_0000, 3'd5, '0);
        send_word(rct_pkg::FN_SETCNT,  32'd7, '0,            '0,   '0);
        send_word(rct_pkg::FN_RELEASE, 32'd7, '0,            '0,   '0);
        send_word(rct_pkg::FN_QUERY,   32'd9, '0,            '0,   '0);
        send_word(3'd6,                32'd7, 32'd1,         '0,   '0);
        send_word(3'd7,                '1,    '1,            '1,   '1);
        send_word(rct_pkg::FN_RELEASE, '1,    '0,            '0,   '0);
        send_word(rct_pkg::FN_COLLECT, '0,    '0,            '0,   '0);

        // Random phases over several register settings
        drain();
        reg_write(rct_pkg::ADDR_THRESH, 32'hFFFF_0000);
        reg_write(rct_pkg::ADDR_THRESH, 32'd3);
        reg_write(rct_pkg::ADDR_AUTO, 32'd1);
        random_words(140);
        drain();
        reg_write(rct_pkg::ADDR_THRESH, 32'h0000_FFFF);
        reg_write(rct_pkg::ADDR_AUTO, 32'hFFFF_FFFE);
        random_words(140);
        drain();
        reg_write(rct_pkg::ADDR_THRESH, 32'd1);
        reg_write(rct_pkg::ADDR_AUTO, 32'd1);
        random_words(80);

        // Last part without idling: grow a long table, then long scans
        drain();
        quiet <= 1'b1;
        reg_write(rct_pkg::ADDR_AUTO, 32'd0);
        for (int i = 0; i < 150; i++)
            send_word(rct_pkg::FN_TRACK, 32'h1000 + i, 32'h0100_0000 + i, 3'(i), '0);
        send_word(rct_pkg::FN_QUERY,   32'h1000 + 149, '0, '0, '0);
        send_word(rct_pkg::FN_SETCNT,  32'h1000 + 100, '0, '0, '0);
        send_word(rct_pkg::FN_RELEASE, 32'h1000,       '0, '0, '0);
        send_word(rct_pkg::FN_COLLECT, '0,             '0, '0, '0);
        send_word(rct_pkg::FN_TRACK,   32'h77,         32'd1, 3'd2, '0);
        send_word(rct_pkg::FN_SETCNT,  32'h1001,       '0, '0, '0);
        drain();
        reg_write(rct_pkg::ADDR_THRESH, 32'd1);
        reg_write(rct_pkg::ADDR_AUTO, 32'd1);
        send_word(rct_pkg::FN_TRACK,   32'h78,         32'd9, 3'd4, '0);
        random_words(30);

        drain();
        repeat (2200) @(posedge i_clk);
        $display("Sent %0d request words and checked %0d result words,", words_sent, results);
        $display("covering all operations, several sweep settings and scans of a long table.");
        if (fails == 0 && pending == 0) begin
            $display("** reference_count_table_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", fails, pending);
            $display("** reference_count_table_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("** reference_count_table_core: FAILED **");
        $finish;
    end
endmodule
